/* sv/apr_pkg.sv */
// Shared types and constants for the aging page replacement block.
package apr_pkg;

    localparam int MODE_W   = 2;
    localparam int FRAME_W  = 6;
    localparam int OWNER_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REF     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [2:0] INSERT_AGE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REF,
        ST_AGE,
        ST_COPY
    } t_state;

endpackage

/* sv/apr_ifs.sv */
// Request and response channel interfaces.
interface apr_in_if import apr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame_number;
    logic [OWNER_W-1:0] owner_id;

    modport source (output valid, mode, frame_number, owner_id, input ready);
    modport sink   (input valid, mode, frame_number, owner_id, output ready);
endinterface

interface apr_out_if import apr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  victim_frame;
    logic [OWNER_W-1:0]  victim_owner;
    logic                invalidate;

    modport source (output valid, status, victim_frame, victim_owner, invalidate, input ready);
    modport sink   (input valid, status, victim_frame, victim_owner, invalidate, output ready);
endinterface

/* sv/apr_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
module apr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/aging_page_replacement_top.sv */
// Aging page replacement tracker, top level.
// Insert, reference, unused mode and replace on an empty ring: registered result in the cycle after the transfer.
// A reference holds off the next request for its read-modify-write.
// Replace: one ring slot per cycle through the
// ring and entry memories for aging and scan, then one per cycle to move slots before the victim.
// Synchronous reset clears tracked bits, ring pointers and output valid; memories are not cleared.
module aging_page_replacement_top import apr_pkg::*; #(
    parameter int NUM_FRAMES = 64,
    parameter int OWNER_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    apr_in_if.sink   i_req,
    apr_out_if.source o_rsp
);
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int EW = OWNER_BITS + 4;

    function automatic logic [FW-1:0] wrap(input logic [FW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(NUM_FRAMES)) begin
            s = s - (CW+1)'(NUM_FRAMES);
        end
        return FW'(s);
    endfunction

    t_state                r_state, n_state;
    logic [FW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [NUM_FRAMES-1:0] r_tracked, n_tracked;
    logic [CW-1:0]         r_iss, n_iss;
    logic                  r_p1_v, n_p1_v;
    logic [CW-1:0]         r_p1_i, n_p1_i;
    logic                  r_p2_v, n_p2_v;
    logic [CW-1:0]         r_p2_i, n_p2_i;
    logic [FW-1:0]         r_p2_f, n_p2_f;
    logic [CW-1:0]         r_best_i, n_best_i;
    logic [2:0]            r_best_age, n_best_age;
    logic [FW-1:0]         r_best_f, n_best_f;
    logic [OWNER_BITS-1:0] r_best_own, n_best_own;
    logic [FW-1:0]         r_ref_f, n_ref_f;
    logic                  r_ov, n_ov;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [FRAME_W-1:0]    r_vframe, n_vframe;
    logic [OWNER_W-1:0]    r_vowner, n_vowner;
    logic                  r_inv, n_inv;

    logic          ring_we;
    logic [FW-1:0] ring_waddr, ring_wdata, ring_raddr, ring_rdata;
    logic          ent_we;
    logic [FW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;

    logic          acc;
    logic          in_range;
    logic [FW-1:0] fidx;
    logic [2:0]    aged;
    logic [FW-1:0] tail_base;

    apr_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    apr_ram #(.WIDTH(EW), .DEPTH(NUM_FRAMES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign i_req.ready        = (r_state == ST_IDLE) && (!r_ov || o_rsp.ready);
    assign acc                = i_req.valid && i_req.ready;
    assign fidx               = FW'(i_req.frame_number);
    assign in_range           = int'(i_req.frame_number) < NUM_FRAMES;
    assign aged               = {ent_rdata[0], ent_rdata[3:2]};
    assign tail_base          = wrap(r_head, r_count);

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_status;
    assign o_rsp.victim_frame = r_vframe;
    assign o_rsp.victim_owner = r_vowner;
    assign o_rsp.invalidate   = r_inv;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_tracked  = r_tracked;
        n_iss      = r_iss;
        n_p1_v     = r_p1_v;
        n_p1_i     = r_p1_i;
        n_p2_v     = r_p2_v;
        n_p2_i     = r_p2_i;
        n_p2_f     = r_p2_f;
        n_best_i   = r_best_i;
        n_best_age = r_best_age;
        n_best_f   = r_best_f;
        n_best_own = r_best_own;
        n_ref_f    = r_ref_f;
        n_ov       = r_ov && !o_rsp.ready;
        n_status   = r_status;
        n_vframe   = r_vframe;
        n_vowner   = r_vowner;
        n_inv      = r_inv;
        ring_we    = 1'b0;
        ring_waddr = tail_base;
        ring_wdata = fidx;
        ring_raddr = wrap(r_head, r_iss);
        ent_we     = 1'b0;
        ent_waddr  = fidx;
        ent_wdata  = {OWNER_BITS'(i_req.owner_id), INSERT_AGE, 1'b0};
        ent_raddr  = (r_state == ST_AGE) ? ring_rdata : fidx;

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_ov     = 1'b1;
                    n_status = STAT_OK;
                    n_vframe = '0;
                    n_vowner = '0;
                    n_inv    = 1'b0;
                    case (i_req.mode)
                        MODE_INSERT: begin
                            if (!in_range || r_tracked[fidx] || r_count == CW'(NUM_FRAMES)) begin
                                n_status = STAT_FULL;
                            end else begin
                                ent_we          = 1'b1;
                                ring_we         = 1'b1;
                                n_tracked[fidx] = 1'b1;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        MODE_REF: begin
                            if (in_range && r_tracked[fidx]) begin
                                n_state = ST_REF;
                                n_ref_f = fidx;
                            end
                        end
                        MODE_REPLACE: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_ov    = 1'b0;
                                n_state = ST_AGE;
                                n_iss   = '0;
                                n_p1_v  = 1'b0;
                                n_p2_v  = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REF: begin
                ent_we    = 1'b1;
                ent_waddr = r_ref_f;
                ent_wdata = {ent_rdata[EW-1:1], 1'b1};
                n_state   = ST_IDLE;
            end
            ST_AGE: begin
                n_p1_v = 1'b0;
                if (r_iss < r_count) begin
                    n_p1_v = 1'b1;
                    n_p1_i = r_iss;
                    n_iss  = r_iss + 1'b1;
                end
                n_p2_v = r_p1_v;
                n_p2_i = r_p1_i;
                n_p2_f = ring_rdata;
                if (r_p2_v) begin
                    ent_we    = 1'b1;
                    ent_waddr = r_p2_f;
                    ent_wdata = {ent_rdata[EW-1:4], aged, 1'b0};
                    if (r_p2_i == '0 || aged < r_best_age) begin
                        n_best_i   = r_p2_i;
                        n_best_age = aged;
                        n_best_f   = r_p2_f;
                        n_best_own = ent_rdata[EW-1:4];
                    end
                    if (r_p2_i == r_count - 1'b1) begin
                        n_state = ST_COPY;
                        n_iss   = '0;
                        n_p1_v  = 1'b0;
                        n_p2_v  = 1'b0;
                    end
                end
            end
            ST_COPY: begin
                n_p1_v = 1'b0;
                if (r_iss < r_best_i) begin
                    n_p1_v = 1'b1;
                    n_p1_i = r_iss;
                    n_iss  = r_iss + 1'b1;
                end
                if (r_p1_v) begin
                    ring_we    = 1'b1;
                    ring_waddr = wrap(tail_base, r_p1_i);
                    ring_wdata = ring_rdata;
                end
                if (!(r_iss < r_best_i) && !r_p1_v) begin
                    n_head              = wrap(r_head, r_best_i + 1'b1);
                    n_count             = r_count - 1'b1;
                    n_tracked[r_best_f] = 1'b0;
                    n_ov                = 1'b1;
                    n_status            = STAT_OK;
                    n_vframe            = FRAME_W'(r_best_f);
                    n_vowner            = OWNER_W'(r_best_own);
                    n_inv               = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_tracked <= '0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_tracked <= n_tracked;
            r_p1_v    <= n_p1_v;
            r_p2_v    <= n_p2_v;
            r_ov      <= n_ov;
        end
        r_iss      <= n_iss;
        r_p1_i     <= n_p1_i;
        r_p2_i     <= n_p2_i;
        r_p2_f     <= n_p2_f;
        r_best_i   <= n_best_i;
        r_best_age <= n_best_age;
        r_best_f   <= n_best_f;
        r_best_own <= n_best_own;
        r_ref_f    <= n_ref_f;
        r_status   <= n_status;
        r_vframe   <= n_vframe;
        r_vowner   <= n_vowner;
        r_inv      <= n_inv;
    end
endmodule

/* sv/apr_chk.sv */
// Port-level checker for the aging page replacement top level, with its bind.
module apr_chk import apr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_rsp_status,
    input logic [FRAME_W-1:0]  i_rsp_frame,
    input logic [OWNER_W-1:0]  i_rsp_owner,
    input logic                i_rsp_inv
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_hold_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_frame) && $stable(i_rsp_inv))
        else $error("response payload changed while stalled");

    a_inv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_inv |-> i_rsp_status == STAT_OK)
        else $error("victim reported with error status");

    a_no_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_inv |-> i_rsp_frame == '0 && i_rsp_owner == '0)
        else $error("victim fields set without invalidate");
endmodule

bind aging_page_replacement_top apr_chk u_apr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_frame  (o_rsp.victim_frame),
    .i_rsp_owner  (o_rsp.victim_owner),
    .i_rsp_inv    (o_rsp.invalidate)
);

/* dv/aging_page_replacement_top_tb.sv */
// Self-checking testbench for the aging page replacement block: directed table, fill and overflow, then random traffic.
module aging_page_replacement_top_tb;
    import apr_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] frame;
        logic [OWNER_W-1:0] owner;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  vframe;
        logic [OWNER_W-1:0]  vowner;
        logic                inval;
    } t_rsp;

    typedef struct packed {
        t_req req;
        logic has_rsp;
        t_rsp rsp;
    } t_row;

    localparam int NF        = 64;
    localparam int CYC_LIMIT = 1500000;

    logic i_clk;
    logic i_rst_n;
    apr_in_if  req_if ();
    apr_out_if rsp_if ();

    aging_page_replacement_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // predictor state
    logic        pm_tracked [NF];
    logic [15:0] pm_owner   [NF];
    logic [2:0]  pm_age     [NF];
    logic        pm_ref     [NF];
    logic [5:0]  pm_ring    [NF];
    int          pm_count;

    t_rsp rsp_q[$];
    logic chk_q[$];
    t_rsp fix_q[$];
    int   err_cnt = 0;
    int   cyc = 0;
    logic rx_idle_en;
    logic tx_idle_en;
    logic hold_rx;

    t_row dir_tbl[$];

    function automatic t_rsp predict_page(t_req r);
        t_rsp o;
        int best, n;
        logic [5:0] f, rot[NF];
        o = '0;
        case (r.mode)
            MODE_INSERT: begin
                if (pm_tracked[r.frame] || pm_count >= NF) begin
                    o.status = STAT_FULL;
                end else begin
                    pm_tracked[r.frame] = 1'b1;
                    pm_owner[r.frame]   = r.owner;
                    pm_age[r.frame]     = INSERT_AGE;
                    pm_ref[r.frame]     = 1'b0;
                    pm_ring[pm_count]   = r.frame;
                    pm_count++;
                end
            end
            MODE_REF: begin
                if (pm_tracked[r.frame]) pm_ref[r.frame] = 1'b1;
            end
            MODE_REPLACE: begin
                if (pm_count == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    for (int i = 0; i < pm_count; i++) begin
                        f = pm_ring[i];
                        pm_age[f] = {pm_ref[f], pm_age[f][2:1]};
                        pm_ref[f] = 1'b0;
                    end
                    best = 0;
                    for (int i = 0; i < pm_count; i++) begin
                        if (pm_age[pm_ring[i]] < pm_age[pm_ring[best]]) best = i;
                        if (pm_age[pm_ring[i]] == 3'd0) begin
                            best = i;
                            break;
                        end
                    end
                    f = pm_ring[best];
                    o.vframe = f;
                    o.vowner = pm_owner[f];
                    o.inval  = 1'b1;
                    pm_tracked[f] = 1'b0;
                    n = 0;
                    for (int i = best + 1; i < pm_count; i++) rot[n++] = pm_ring[i];
                    for (int i = 0; i < best; i++) rot[n++] = pm_ring[i];
                    for (int i = 0; i < n; i++) pm_ring[i] = rot[i];
                    pm_count = n;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, t_rsp got, t_rsp exp);
        $display("MISMATCH %s: got st=%0d vf=%0d vo=%0h inv=%0b exp st=%0d vf=%0d vo=%0h inv=%0b",
                 what, got.status, got.vframe, got.vowner, got.inval,
                 exp.status, exp.vframe, exp.vowner, exp.inval);
        err_cnt++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("timeout");
            $display("aging_page_replacement_top regression: fail");
            $finish;
        end
    end

    // response side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                t_rsp got, exp, pin;
                got = {rsp_if.status, rsp_if.victim_frame, rsp_if.victim_owner,
                       rsp_if.invalidate};
                if (rsp_q.size() == 0) begin
                    report_mismatch("unexpected transfer", got, '0);
                end else begin
                    exp = rsp_q.pop_front();
                    if (chk_q.pop_front()) begin
                        pin = fix_q.pop_front();
                        if (pin !== exp) report_mismatch("table vs predictor", pin, exp);
                    end
                    if (got.status !== exp.status) report_mismatch("status", got, exp);
                    if (got.vframe !== exp.vframe) report_mismatch("victim_frame", got, exp);
                    if (got.vowner !== exp.vowner) report_mismatch("victim_owner", got, exp);
                    if (got.inval !== exp.inval) report_mismatch("invalidate", got, exp);
                end
            end
            rsp_if.ready <= !hold_rx && !(rx_idle_en && $urandom_range(99) < 15);
        end
    end

    task automatic send_req(t_req r, logic has_fix, t_rsp fix);
        req_if.valid        <= 1'b1;
        req_if.mode         <= r.mode;
        req_if.frame_number <= r.frame;
        req_if.owner_id     <= r.owner;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        rsp_q.push_back(predict_page(r));
        chk_q.push_back(has_fix);
        if (has_fix) fix_q.push_back(fix);
        if (tx_idle_en) begin
            while ($urandom_range(99) < 15) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    function automatic t_req rand_req(int phase);
        t_req r;
        int p;
        p = $urandom_range(99);
        r.owner = OWNER_W'($urandom);
        r.frame = (phase == 0) ? FRAME_W'($urandom_range(7)) : FRAME_W'($urandom);
        if (p < 3)       r.mode = 2'd3;
        else if (p < 45) r.mode = MODE_INSERT;
        else if (p < 75) r.mode = MODE_REF;
        else             r.mode = MODE_REPLACE;
        return r;
    endfunction

    function automatic t_row mk(logic [1:0] m, logic [5:0] f, logic [15:0] o,
                                logic h, t_rsp e);
        t_row w;
        w.req = '{m, f, o};
        w.has_rsp = h;
        w.rsp = e;
        return w;
    endfunction

    initial begin
        t_rsp z;
        z = '0;
        hold_rx = 1'b0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        for (int i = 0; i < NF; i++) begin
            pm_tracked[i] = 1'b0; pm_owner[i] = '0; pm_age[i] = '0;
            pm_ref[i] = 1'b0; pm_ring[i] = '0;
        end
        pm_count = 0;
        req_if.valid = 1'b0;
        req_if.mode = '0;
        req_if.frame_number = '0;
        req_if.owner_id = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_tbl.push_back(mk(MODE_REPLACE, 6'd0, 16'h0, 1'b1, '{STAT_EMPTY, 0, 0, 0}));
        dir_tbl.push_back(mk(MODE_REF, 6'd5, 16'hffff, 1'b1, z));
        dir_tbl.push_back(mk(2'd3, 6'd63, 16'hffff, 1'b1, z));
        dir_tbl.push_back(mk(MODE_INSERT, 6'd0, 16'hffff, 1'b1, z));
        dir_tbl.push_back(mk(MODE_INSERT, 6'd63, 16'h0000, 1'b1, z));
        dir_tbl.push_back(mk(MODE_INSERT, 6'd0, 16'h1234, 1'b1, '{STAT_FULL, 0, 0, 0}));
        dir_tbl.push_back(mk(MODE_INSERT, 6'd21, 16'haaaa, 1'b1, z));
        dir_tbl.push_back(mk(MODE_INSERT, 6'd42, 16'h5555, 1'b1, z));
        dir_tbl.push_back(mk(MODE_REF, 6'd0, 16'h0, 1'b1, z));
        dir_tbl.push_back(mk(MODE_REF, 6'd63, 16'h0, 1'b1, z));
        dir_tbl.push_back(mk(MODE_REPLACE, 6'd63, 16'hffff, 1'b0, z));
        dir_tbl.push_back(mk(MODE_REPLACE, 6'd0, 16'h0, 1'b0, z));
        // frames 0 and 63 are referenced before each replace, with fresh unreferenced inserts between
        for (int k = 0; k < 3; k++) begin
            dir_tbl.push_back(mk(MODE_REF, 6'd0, 16'h0, 1'b1, z));
            dir_tbl.push_back(mk(MODE_REF, 6'd63, 16'h0, 1'b1, z));
            dir_tbl.push_back(mk(MODE_REPLACE, 6'd0, 16'h0, 1'b0, z));
            if (k < 2) begin
                dir_tbl.push_back(mk(MODE_INSERT, 6'(21 + k), 16'h0f0f, 1'b1, z));
            end
        end
        dir_tbl.push_back(mk(MODE_REPLACE, 6'd0, 16'h0, 1'b0, z));
        dir_tbl.push_back(mk(MODE_REPLACE, 6'd0, 16'h0, 1'b0, z));
        foreach (dir_tbl[i]) send_req(dir_tbl[i].req, dir_tbl[i].has_rsp, dir_tbl[i].rsp);

        // fill the ring to capacity, overflow, then mix references with replaces that drain part of it
        for (int f = 0; f < NF; f++) send_req('{MODE_INSERT, 6'(f), 16'($urandom)}, 1'b0, z);
        send_req('{MODE_INSERT, 6'd7, 16'h0}, 1'b0, z);
        for (int k = 0; k < 40; k++) begin
            send_req('{MODE_REF, 6'($urandom), 16'h0}, 1'b0, z);
            if (k % 4 == 0) send_req('{MODE_REPLACE, 6'd0, 16'h0}, 1'b0, z);
        end

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int k = 0; k < 20; k++) send_req(rand_req(1), 1'b0, z);
        join

        for (int k = 0; k < 600; k++) begin
            if (k == 200) begin
                rx_idle_en = 1'b0; tx_idle_en = 1'b0;
            end
            if (k == 320) begin
                rx_idle_en = 1'b1; tx_idle_en = 1'b1;
            end
            send_req(rand_req(k % 150 < 60 ? 0 : 1), 1'b0, z);
        end
        req_if.valid <= 1'b0;

        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("aging_page_replacement_top regression: pass");
        end else begin
            $display("aging_page_replacement_top regression: fail");
        end
        $finish;
    end
endmodule
